// ----- rtl/moe_rt_pkg.sv -----
// Shared types, constants and the sigmoid table for the top-k expert router.
`default_nettype none
package moe_rt_pkg;

  localparam int MAX_SELECT_DEF  = 8;
  localparam int MAX_SHARED_DEF  = 4;
  localparam int MAX_EXPERTS_DEF = 256;

  localparam int CNT_W  = 10;  // routed (9 bits) plus shared (3 bits) items
  localparam int SIG_W  = 17;  // sigmoid, unsigned Q1.16, stays below 1.0
  localparam int PROD_W = 33;  // sigmoid times weight scale
  localparam int NUM_W  = 42;  // dividend for the weight division
  localparam int WGT_W  = 24;

  localparam logic [1:0] REG_ROUTED = 2'd0;
  localparam logic [1:0] REG_SHARED = 2'd1;
  localparam logic [1:0] REG_SELECT = 2'd2;
  localparam logic [1:0] REG_SCALE  = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_BAD_CFG  = 2'd1;
  localparam logic [1:0] STS_ZERO_SUM = 2'd2;

  localparam logic KIND_ROUTED = 1'b0;
  localparam logic KIND_SHARED = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCORE,
    ST_SUM_REQ,
    ST_SUM_WAIT,
    ST_W_REQ,
    ST_W_WAIT,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } state_t;

  // sigmoid at 0, 0.5, ... 8.0 in Q0.16
  function automatic logic [15:0] sig_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/moe_topk_router_unit.sv -----
// Top level of the sigmoid top-k expert router.
//
//   channel | signals                                        | direction
//   in      | in_valid, in_ready, logit, bias                | into block
//   out     | out_valid, out_ready, kind, expert_index,      | out of block
//           | weight, status, last                           |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | into block
//
// A mid-run item is accepted and passes through the sigmoid unit, with the
// top-k update when its sigmoid result arrives; no new item is taken meanwhile.
// The last item adds one sigmoid pass per chosen or shared expert for the sum,
// then per result a sigmoid, a multiply and a 42-step restoring division.
// Reset is synchronous; it restores the register defaults and empties the run.
// A result waits in the output register while out_ready is low; only the next
// result waits behind it. A register write empties the run but keeps the state.
`default_nettype none
module moe_topk_router_unit #(
  parameter int MAX_SELECT  = moe_rt_pkg::MAX_SELECT_DEF,
  parameter int MAX_SHARED  = moe_rt_pkg::MAX_SHARED_DEF,
  parameter int MAX_EXPERTS = moe_rt_pkg::MAX_EXPERTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] logit,
  input  wire logic signed [15:0] bias,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    kind,
  output logic [7:0]              expert_index,
  output logic [23:0]             weight,
  output logic [1:0]              status,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int ENT_N = MAX_SELECT + MAX_SHARED;
  localparam int ENT_W = $clog2(ENT_N + 1);
  localparam int SH_D  = (MAX_SHARED > 0) ? MAX_SHARED : 1;
  localparam int SUM_W = $clog2(ENT_N * 65536 + 1);

  moe_rt_pkg::state_t state, state_next;

  logic [8:0]  routed_count;
  logic [2:0]  shared_count;
  logic [3:0]  select_count;
  logic [15:0] weight_scale;

  logic signed [17:0] rank_score [MAX_SELECT];
  logic [7:0]         rank_index [MAX_SELECT];
  logic signed [15:0] rank_logit [MAX_SELECT];
  logic [MAX_SELECT-1:0] rank_valid;
  logic signed [15:0] shared_logit [SH_D];
  logic [moe_rt_pkg::CNT_W-1:0] item_counter;

  logic signed [15:0] logit_q;
  logic signed [15:0] bias_q;
  logic [ENT_W-1:0]   ent;
  logic [SUM_W-1:0]   sum;
  logic [moe_rt_pkg::SIG_W-1:0]  s_q;
  logic [moe_rt_pkg::PROD_W-1:0] prod_q;
  logic [23:0] w_q;
  logic [1:0]  err_sts;
  logic        cur_kind;
  logic [7:0]  cur_idx;
  logic        cur_last;

  logic in_acc, cfg_acc, cfg_bad, out_free, out_load;
  logic sig_start, sig_done, div_start, div_done;
  logic [moe_rt_pkg::SIG_W-1:0] sig_res;
  logic signed [15:0] sig_arg;
  logic [moe_rt_pkg::NUM_W-1:0] div_num, div_q;
  logic fin, is_routed;
  logic ent_end, ent_used, ent_last;
  logic signed [15:0] ent_logit;
  logic [7:0]  ent_idx;
  logic [MAX_SELECT:0] rv_ext;
  logic signed [17:0] score;
  logic [MAX_SELECT-1:0] hit;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign cfg_bad = (routed_count == 9'd0) || (int'(routed_count) > MAX_EXPERTS) ||
                   (int'(shared_count) > MAX_SHARED) || (select_count == 4'd0) ||
                   (int'(select_count) > MAX_SELECT) ||
                   ({5'd0, select_count} > routed_count);

  assign is_routed = int'(item_counter) < int'(routed_count);
  assign fin = (int'(item_counter) + 1) >= (int'(routed_count) + int'(shared_count));
  assign score = $signed({5'd0, sig_res[16:4]}) + 18'(bias_q);
  assign rv_ext = {1'b0, rank_valid};

  // top-k slots stay sorted, so the hits form a suffix of the active slots
  always_comb begin
    for (int j = 0; j < MAX_SELECT; j++) begin
      hit[j] = (j < int'(select_count)) && (!rank_valid[j] || score > rank_score[j]);
    end
  end

  always_comb begin
    ent_end   = int'(ent) == ENT_N;
    ent_used  = 1'b0;
    ent_last  = 1'b0;
    ent_logit = '0;
    ent_idx   = '0;
    for (int j = 0; j < MAX_SELECT; j++) begin
      if (int'(ent) == j) begin
        ent_used  = rank_valid[j];
        ent_logit = rank_logit[j];
        ent_idx   = rank_index[j];
        ent_last  = (shared_count == 3'd0) && !rv_ext[j + 1];
      end
    end
    for (int j = 0; j < MAX_SHARED; j++) begin
      if (int'(ent) == MAX_SELECT + j) begin
        ent_used  = j < int'(shared_count);
        ent_logit = shared_logit[j];
        ent_idx   = 8'(j);
        ent_last  = (j + 1) == int'(shared_count);
      end
    end
  end

  assign sig_arg = (state == moe_rt_pkg::ST_IDLE) ? logit : ent_logit;
  assign div_num = {1'b0, prod_q, 8'd0} + moe_rt_pkg::NUM_W'(sum >> 1);

  moe_rt_sig u_sig (
    .clk   (clk),
    .rst   (rst),
    .start (sig_start),
    .arg   (sig_arg),
    .done  (sig_done),
    .res   (sig_res)
  );

  moe_rt_div #(
    .NUM_W (moe_rt_pkg::NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sum),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      moe_rt_pkg::ST_IDLE:
        if (in_acc) state_next = cfg_bad ? moe_rt_pkg::ST_ERR : moe_rt_pkg::ST_SCORE;
      moe_rt_pkg::ST_SCORE:
        if (sig_done) state_next = fin ? moe_rt_pkg::ST_SUM_REQ : moe_rt_pkg::ST_IDLE;
      moe_rt_pkg::ST_SUM_REQ: begin
        if (ent_end) begin
          state_next = (sum == '0) ? moe_rt_pkg::ST_ERR : moe_rt_pkg::ST_W_REQ;
        end else if (ent_used) begin
          state_next = moe_rt_pkg::ST_SUM_WAIT;
        end
      end
      moe_rt_pkg::ST_SUM_WAIT:
        if (sig_done) state_next = moe_rt_pkg::ST_SUM_REQ;
      moe_rt_pkg::ST_W_REQ: begin
        if (ent_end) begin
          state_next = moe_rt_pkg::ST_IDLE;
        end else if (ent_used) begin
          state_next = moe_rt_pkg::ST_W_WAIT;
        end
      end
      moe_rt_pkg::ST_W_WAIT:
        if (sig_done) state_next = moe_rt_pkg::ST_MUL;
      moe_rt_pkg::ST_MUL:    state_next = moe_rt_pkg::ST_DSTART;
      moe_rt_pkg::ST_DSTART: state_next = moe_rt_pkg::ST_DIV;
      moe_rt_pkg::ST_DIV:
        if (div_done) state_next = moe_rt_pkg::ST_EMIT;
      moe_rt_pkg::ST_EMIT:
        if (out_free) state_next = cur_last ? moe_rt_pkg::ST_IDLE : moe_rt_pkg::ST_W_REQ;
      moe_rt_pkg::ST_ERR:
        if (out_free) state_next = moe_rt_pkg::ST_IDLE;
      default: state_next = moe_rt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == moe_rt_pkg::ST_IDLE;
    sig_start = ((state == moe_rt_pkg::ST_IDLE) && in_valid && !cfg_bad) ||
                (((state == moe_rt_pkg::ST_SUM_REQ) || (state == moe_rt_pkg::ST_W_REQ)) &&
                 !ent_end && ent_used);
    div_start = state == moe_rt_pkg::ST_DSTART;
    out_load  = (state == moe_rt_pkg::ST_EMIT) || (state == moe_rt_pkg::ST_ERR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= moe_rt_pkg::ST_IDLE;
      routed_count <= 9'd256;
      shared_count <= 3'd0;
      select_count <= 4'd6;
      weight_scale <= 16'd256;
      rank_valid   <= '0;
      item_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (out_load && out_free) || (out_valid && !out_ready);

      if (cfg_acc) begin
        case (cfg_index)
          moe_rt_pkg::REG_ROUTED: routed_count <= cfg_data[8:0];
          moe_rt_pkg::REG_SHARED: shared_count <= cfg_data[2:0];
          moe_rt_pkg::REG_SELECT: select_count <= cfg_data[3:0];
          moe_rt_pkg::REG_SCALE:  weight_scale <= cfg_data;
          default: ;
        endcase
        rank_valid   <= '0;
        item_counter <= '0;
      end else begin
        case (state)
          moe_rt_pkg::ST_IDLE: begin
            if (in_acc && cfg_bad) begin
              rank_valid   <= '0;
              item_counter <= '0;
            end
          end
          moe_rt_pkg::ST_SCORE: begin
            if (sig_done) begin
              if (is_routed) begin
                for (int j = 0; j < MAX_SELECT; j++) begin
                  if (hit[j]) begin
                    rank_valid[j] <= (j == 0) ? 1'b1 : (hit[j - (j > 0 ? 1 : 0)] ?
                                     rank_valid[j - (j > 0 ? 1 : 0)] : 1'b1);
                  end
                end
              end
              item_counter <= fin ? '0 : item_counter + 1'b1;
            end
          end
          moe_rt_pkg::ST_SUM_REQ: begin
            if (ent_end && sum == '0) begin
              rank_valid   <= '0;
              item_counter <= '0;
            end
          end
          moe_rt_pkg::ST_W_REQ: begin
            if (ent_end) begin
              rank_valid   <= '0;
              item_counter <= '0;
            end
          end
          moe_rt_pkg::ST_EMIT: begin
            if (out_free && cur_last) begin
              rank_valid   <= '0;
              item_counter <= '0;
            end
          end
          default: ;
        endcase
      end
    end

    // payload
    if (in_acc) begin
      logit_q <= logit;
      bias_q  <= bias;
      err_sts <= moe_rt_pkg::STS_BAD_CFG;
    end

    if (state == moe_rt_pkg::ST_SCORE && sig_done) begin
      if (is_routed) begin
        for (int j = 0; j < MAX_SELECT; j++) begin
          if (hit[j]) begin
            if (j == 0 || !hit[j - (j > 0 ? 1 : 0)]) begin
              rank_score[j] <= score;
              rank_index[j] <= item_counter[7:0];
              rank_logit[j] <= logit_q;
            end else begin
              rank_score[j] <= rank_score[j - (j > 0 ? 1 : 0)];
              rank_index[j] <= rank_index[j - (j > 0 ? 1 : 0)];
              rank_logit[j] <= rank_logit[j - (j > 0 ? 1 : 0)];
            end
          end
        end
      end else begin
        for (int j = 0; j < MAX_SHARED; j++) begin
          if (int'(item_counter) == int'(routed_count) + j) shared_logit[j] <= logit_q;
        end
      end
      ent <= '0;
      sum <= '0;
    end

    case (state)
      moe_rt_pkg::ST_SUM_REQ: begin
        if (ent_end) begin
          ent     <= '0;
          err_sts <= moe_rt_pkg::STS_ZERO_SUM;
        end else if (!ent_used) begin
          ent <= ent + 1'b1;
        end
      end
      moe_rt_pkg::ST_SUM_WAIT: begin
        if (sig_done) begin
          sum <= sum + SUM_W'(sig_res);
          ent <= ent + 1'b1;
        end
      end
      moe_rt_pkg::ST_W_REQ: begin
        if (!ent_end) begin
          if (ent_used) begin
            cur_kind <= (int'(ent) < MAX_SELECT) ? moe_rt_pkg::KIND_ROUTED
                                                 : moe_rt_pkg::KIND_SHARED;
            cur_idx  <= ent_idx;
            cur_last <= ent_last;
          end else begin
            ent <= ent + 1'b1;
          end
        end
      end
      moe_rt_pkg::ST_W_WAIT: if (sig_done) s_q <= sig_res;
      moe_rt_pkg::ST_MUL: prod_q <= moe_rt_pkg::PROD_W'(s_q) * moe_rt_pkg::PROD_W'(weight_scale);
      moe_rt_pkg::ST_DIV: begin
        if (div_done) begin
          w_q <= (|div_q[moe_rt_pkg::NUM_W-1:moe_rt_pkg::WGT_W]) ? 24'hFF_FFFF
                                                                 : div_q[23:0];
        end
      end
      moe_rt_pkg::ST_EMIT: if (out_free) ent <= ent + 1'b1;
      default: ;
    endcase

    if (out_load && out_free) begin
      if (state == moe_rt_pkg::ST_ERR) begin
        kind         <= moe_rt_pkg::KIND_ROUTED;
        expert_index <= 8'd0;
        weight       <= 24'd0;
        status       <= err_sts;
        last         <= 1'b1;
      end else begin
        kind         <= cur_kind;
        expert_index <= cur_idx;
        weight       <= w_q;
        status       <= moe_rt_pkg::STS_OK;
        last         <= cur_last;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/moe_rt_sig.sv -----
// Two-stage sigmoid unit: table lookup with linear interpolation.
`default_nettype none
module moe_rt_sig (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic signed [15:0]              arg,
  output logic                                 done,
  output logic [moe_rt_pkg::SIG_W-1:0]         res
);

  logic [16:0] mag;
  logic [5:0]  seg;
  logic [10:0] frac;
  logic [15:0] base_c;
  logic [12:0] diff_c;

  logic        v1;
  logic        neg1;
  logic [15:0] base1;
  logic [23:0] prod1;
  logic [16:0] pos;

  always_comb begin
    mag  = arg[15] ? (17'd0 - {arg[15], arg}) : {1'b0, arg};
    seg  = mag[16:11];
    frac = mag[10:0];
    if (seg >= 6'd16) begin
      base_c = moe_rt_pkg::sig_tab(5'd16);
      diff_c = 13'd0;
    end else begin
      base_c = moe_rt_pkg::sig_tab(seg[4:0]);
      diff_c = 13'(moe_rt_pkg::sig_tab(seg[4:0] + 5'd1) - moe_rt_pkg::sig_tab(seg[4:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
    neg1  <= arg[15];
    base1 <= base_c;
    prod1 <= 24'(diff_c) * 24'(frac);
    res   <= neg1 ? (17'h10000 - pos) : pos;
  end

  assign pos = {1'b0, base1} + 17'(prod1 >> 11);

endmodule
`default_nettype wire

// ----- rtl/moe_rt_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module moe_rt_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 21
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DEN_W:0] rem;
  logic [DEN_W:0] sh;
  logic           fit;

  assign sh  = {rem[DEN_W-1:0], quot[NUM_W-1]};
  assign fit = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) busy <= 1'b0;
      end
    end
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      rem  <= fit ? (sh - {1'b0, den}) : sh;
      quot <= {quot[NUM_W-2:0], fit};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/moe_rt_chk.sv -----
// Port-level checker for the router, bound to the top level.
`default_nettype none
module moe_rt_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        kind,
  input wire logic [7:0]  expert_index,
  input wire logic [23:0] weight,
  input wire logic [1:0]  status,
  input wire logic        last
);

  // a stalled result stays valid and keeps its weight and expert index
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight) && $stable(expert_index))
    else $error("result changed while stalled");

  // block is not ready in the cycle after taking an item
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != moe_rt_pkg::STS_OK |-> last)
    else $error("error result not marked last");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != moe_rt_pkg::STS_OK |-> weight == 24'd0 && kind == 1'b0 &&
      expert_index == 8'd0)
    else $error("error result carries payload");

endmodule

bind moe_topk_router_unit moe_rt_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .expert_index (expert_index),
  .weight       (weight),
  .status       (status),
  .last         (last)
);
`default_nettype wire
